FILE: src/sds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Softmax direction sampler package
// Shared widths, types and the exp(-d) weight table in unsigned Q1.16.
// ----------------------------------------------------------------------------
package sds_pkg;

   localparam int NUM_DIR       = 4;
   localparam int BYTES_PER_DIR = 8;
   localparam int FRAC_BITS     = 16;
   localparam int EXP_LEN       = 12;

   localparam int DIR_W    = $clog2(NUM_DIR);
   localparam int WORD_W   = 8 * BYTES_PER_DIR;
   localparam int PROD_W   = 17;
   localparam int SCORE_W  = PROD_W + $clog2(BYTES_PER_DIR);
   localparam int DIFF_W   = SCORE_W + 1;
   localparam int WEIGHT_W = FRAC_BITS + 1;
   localparam int CUM_W    = WEIGHT_W + DIR_W;
   localparam int MUL_W    = FRAC_BITS + CUM_W;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;

   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SCORE_W-1:0]  score_type;
   typedef logic        [WEIGHT_W-1:0] weight_type;
   typedef logic        [CUM_W-1:0]    cum_type;
   typedef logic        [MUL_W-1:0]    mul_type;
   typedef logic        [FRAC_BITS-1:0] frac_type;
   typedef logic        [NUM_DIR-1:0]  mask_type;
   typedef logic        [DIR_W-1:0]    dir_type;

   // round(65536 * exp(-d)); zero past the end of the table
   function automatic weight_type exp_weight(input logic [3:0] d);
      weight_type w;
      case (d)
         4'd0:    w = 17'd65536;
         4'd1:    w = 17'd24109;
         4'd2:    w = 17'd8869;
         4'd3:    w = 17'd3263;
         4'd4:    w = 17'd1200;
         4'd5:    w = 17'd442;
         4'd6:    w = 17'd162;
         4'd7:    w = 17'd60;
         4'd8:    w = 17'd22;
         4'd9:    w = 17'd8;
         4'd10:   w = 17'd3;
         4'd11:   w = 17'd1;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: src/sds_score.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Direction score
// Two-stage dot product of unsigned scent bytes with signed weight bytes.
// ----------------------------------------------------------------------------
module sds_score
   import sds_pkg::*;
(
   input  wire logic             clock,
   input  wire logic [WORD_W-1:0] scents,
   input  wire logic [WORD_W-1:0] weights,
   output score_type             score
);

   prod_type  prod_ff [BYTES_PER_DIR];
   prod_type  prod_in [BYTES_PER_DIR];
   score_type score_ff;
   score_type score_in;

   always_comb begin
      for (int i = 0; i < BYTES_PER_DIR; i++) begin
         prod_in[i] = $signed({1'b0, scents[8*i +: 8]}) * $signed(weights[8*i +: 8]);
      end
   end

   always_comb begin
      score_in = '0;
      for (int i = 0; i < BYTES_PER_DIR; i++) begin
         score_in = score_in + SCORE_W'(prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      score_ff <= score_in;
   end

   assign score = score_ff;

endmodule
`default_nettype wire

FILE: src/softmax_direction_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Softmax direction sampler
// Scores each open direction against the weight register, forms softmax
// weights from an exp table and picks a direction with a random fraction.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is accepted every cycle and busy is always low.
// Each result appears on rsp_direction with rsp_valid after the six
// register stages (products, score sum, maximum, weight lookup,
// cumulative sums and product, pick). rsp_valid lasts one cycle; the
// receiver must take it then. Write csr_wr_data only while no word is in
// flight.
// ----------------------------------------------------------------------------
module softmax_direction_sampler
   import sds_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [WORD_W-1:0] req_scents_dir_0,
   input  wire logic [WORD_W-1:0] req_scents_dir_1,
   input  wire logic [WORD_W-1:0] req_scents_dir_2,
   input  wire logic [WORD_W-1:0] req_scents_dir_3,
   input  wire logic [NUM_DIR-1:0] req_open_mask,
   input  wire logic [15:0]       req_random_fraction,
   input  wire logic              csr_wr_en,
   input  wire logic [WORD_W-1:0] csr_wr_data,
   output logic                   rsp_valid,
   output logic [DIR_W-1:0]       rsp_direction
);

   logic [WORD_W-1:0] weights_ff;
   logic [WORD_W-1:0] scent_word [NUM_DIR];
   score_type         score [NUM_DIR];

   logic [4:0] valid_ff;
   logic       accept;

   mask_type mask1_ff, mask2_ff, mask3_ff;
   frac_type rnd1_ff, rnd2_ff, rnd3_ff, rnd4_ff;

   score_type score3_ff [NUM_DIR];
   score_type max3_ff, max3_in;
   logic      any3_ff, any3_in;

   weight_type weight4_ff [NUM_DIR];
   weight_type weight4_in [NUM_DIR];

   cum_type cum5_ff [NUM_DIR];
   cum_type cum5_in [NUM_DIR];
   mul_type mul5_ff, mul5_in;

   dir_type pick_in;
   dir_type direction_ff;
   logic    rsp_valid_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff <= '0;
      end else if (csr_wr_en) begin
         weights_ff <= csr_wr_data;
      end
   end

   assign scent_word[0] = req_scents_dir_0;
   assign scent_word[1] = req_scents_dir_1;
   assign scent_word[2] = req_scents_dir_2;
   assign scent_word[3] = req_scents_dir_3;

   for (genvar d = 0; d < NUM_DIR; d++) begin : g_dir
      sds_score u_score (
         .clock   (clock),
         .scents  (scent_word[d]),
         .weights (weights_ff),
         .score   (score[d])
      );
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[3:0], accept};
         rsp_valid_ff <= valid_ff[4];
      end
   end

   // maximum over open directions
   always_comb begin
      any3_in = 1'b0;
      max3_in = '0;
      for (int d = 0; d < NUM_DIR; d++) begin
         if (mask2_ff[d] && (!any3_in || score[d] > max3_in)) begin
            max3_in = score[d];
         end
         any3_in = any3_in | mask2_ff[d];
      end
   end

   // weight lookup
   always_comb begin
      logic [DIFF_W-1:0] diff;
      for (int d = 0; d < NUM_DIR; d++) begin
         diff = DIFF_W'($signed(max3_ff) - $signed(score3_ff[d]));
         if (!any3_ff) begin
            weight4_in[d] = WEIGHT_ONE;
         end else if (!mask3_ff[d]) begin
            weight4_in[d] = '0;
         end else if (diff < DIFF_W'(EXP_LEN)) begin
            weight4_in[d] = exp_weight(diff[3:0]);
         end else begin
            weight4_in[d] = '0;
         end
      end
   end

   // cumulative weights and scaled random
   always_comb begin
      cum_type acc;
      acc = '0;
      for (int d = 0; d < NUM_DIR; d++) begin
         acc        = acc + CUM_W'(weight4_ff[d]);
         cum5_in[d] = acc;
      end
      mul5_in = MUL_W'(rnd4_ff) * MUL_W'(acc);
   end

   // first direction past the random point
   always_comb begin
      logic found;
      found   = 1'b0;
      pick_in = DIR_W'(NUM_DIR - 1);
      for (int d = 0; d < NUM_DIR; d++) begin
         if (!found && (mul5_ff < (MUL_W'(cum5_ff[d]) << FRAC_BITS))) begin
            pick_in = DIR_W'(d);
            found   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mask1_ff     <= req_open_mask;
      rnd1_ff      <= req_random_fraction[FRAC_BITS-1:0];
      mask2_ff     <= mask1_ff;
      rnd2_ff      <= rnd1_ff;
      mask3_ff     <= mask2_ff;
      rnd3_ff      <= rnd2_ff;
      score3_ff    <= score;
      max3_ff      <= max3_in;
      any3_ff      <= any3_in;
      rnd4_ff      <= rnd3_ff;
      weight4_ff   <= weight4_in;
      cum5_ff      <= cum5_in;
      mul5_ff      <= mul5_in;
      direction_ff <= pick_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_direction = direction_ff;

endmodule
`default_nettype wire

FILE: src/sds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Softmax direction sampler checker
// Port-level checks of busy, latency, unrequested results and of the single-open-direction pick.
// ----------------------------------------------------------------------------
module sds_checker
   import sds_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [NUM_DIR-1:0] req_open_mask,
   input wire logic               rsp_valid,
   input wire logic [DIR_W-1:0]   rsp_direction
);

   a_no_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("word lost in pipeline");

   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 6))
      else $error("result without request");

   a_only_first : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_open_mask, 6) == 4'b0001) |-> rsp_direction == 2'd0)
      else $error("single open direction 0 not picked");

   a_only_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_open_mask, 6) == 4'b1000) |-> rsp_direction == 2'd3)
      else $error("single open direction 3 not picked");

endmodule

bind softmax_direction_sampler sds_checker u_sds_checker (.*);
`default_nettype wire
